@@ rtl/core/ebcdic_dbcs_to_gbk_converter_top_defines.svh @@
// Assertion macros used by the converter top file.
// Each macro expects clk_i and rst_ni in the scope of its use.
`ifndef EBCDIC_DBCS_TO_GBK_CONVERTER_TOP_DEFINES_SVH
`define EBCDIC_DBCS_TO_GBK_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication.
`define E2G_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define E2G_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/e2g_pkg.sv @@
package e2g_pkg;

  localparam int MAP_WORDS   = 36864;
  localparam int MAP_AW      = $clog2(MAP_WORDS);
  localparam int COUNT_WIDTH = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] SHIFT_OUT = 8'h0E;
  localparam logic [7:0] SHIFT_IN  = 8'h0F;
  localparam logic [7:0] DB_BASE   = 8'h40;
  localparam logic [7:0] DB_ROW    = 8'hC0;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_CONVERT = 2'd1,
    CMD_END     = 2'd2
  } command_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  // Work unit passed from front to back
  typedef enum logic [1:0] {
    JOB_BYTE   = 2'd0,
    JOB_PAIR   = 2'd1,
    JOB_STATUS = 2'd2
  } job_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  in_byte;
    logic [15:0] map_address;
    logic [15:0] map_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [15:0] out_length;
    logic        last;
  } out_item_t;

  typedef struct packed {
    job_e        op;
    logic [15:0] word;
    kind_e       kind;
    logic [15:0] length;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [MAP_AW-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [MAP_AW-1:0] raddr;
  } ram_req_t;

  // Single-byte EBCDIC to ASCII table; zero marks an unmapped code
  localparam logic [7:0] SB_ROM [256] = '{
    8'h00,8'h01,8'h02,8'h03,8'h00,8'h09,8'h00,8'h7F,
    8'h00,8'h00,8'h00,8'h0B,8'h0C,8'h0D,8'h00,8'h00,
    8'h10,8'h11,8'h12,8'h13,8'h00,8'h00,8'h08,8'h00,
    8'h18,8'h19,8'h00,8'h00,8'h1C,8'h1D,8'h1E,8'h1F,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h0A,8'h17,8'h1B,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h05,8'h06,8'h07,
    8'h00,8'h00,8'h16,8'h00,8'h00,8'h00,8'h00,8'h04,
    8'h00,8'h00,8'h00,8'h00,8'h14,8'h15,8'h00,8'h1A,
    8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h2E,8'h3C,8'h28,8'h2B,8'h7C,
    8'h26,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h21,8'h00,8'h2A,8'h29,8'h3B,8'h00,
    8'h2D,8'h2F,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h2C,8'h25,8'h5F,8'h3E,8'h3F,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h60,8'h3A,8'h23,8'h40,8'h27,8'h3D,8'h22,
    8'h00,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,
    8'h68,8'h69,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h6A,8'h6B,8'h6C,8'h6D,8'h6E,8'h6F,8'h70,
    8'h71,8'h72,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h7E,8'h00,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,
    8'h79,8'h7A,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h5E,8'h00,8'h5C,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h5B,8'h5D,8'h00,8'h00,8'h00,8'h00,
    8'h7B,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,
    8'h48,8'h49,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h7D,8'h4A,8'h4B,8'h4C,8'h4D,8'h4E,8'h4F,8'h50,
    8'h51,8'h52,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h24,8'h00,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,
    8'h59,8'h5A,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
    8'h38,8'h39,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
  };

endpackage

@@ rtl/core/e2g_ram.sv @@
module e2g_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/e2g_front.sv @@
module e2g_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  e2g_pkg::in_item_t   in_item_i,
  output e2g_pkg::ram_req_t   ram_req_o,
  input  logic [15:0]         ram_rdata_i,
  output logic                q_push_o,
  output e2g_pkg::job_t       q_entry_o,
  input  logic                q_full_i
);

  localparam int CntW = e2g_pkg::COUNT_WIDTH;

  typedef enum logic [2:0] {
    MODE_SINGLE = 3'b001,
    MODE_DOUBLE = 3'b010,
    MODE_HIGH   = 3'b100
  } mode_e;

  mode_e           mode_q, mode_d;
  logic [7:0]      high_byte_q, high_byte_d;
  logic            error_q, error_d;
  logic [CntW-1:0] count_q, count_d;

  logic            stg_valid_q, stg_valid_d;
  e2g_pkg::job_t   stg_q, job_d;

  logic            advance, accept, emit;
  logic [1:0]      add_n;
  logic [CntW:0]   sum;
  logic [31:0]     count_wide;
  logic [15:0]     length;
  logic [7:0]      b, rom_val, hi_off, lo_off;
  logic [15:0]     pair_addr;

  // Stage moves on when empty or when the queue takes its job
  assign advance = !stg_valid_q || !q_full_i;
  assign full    = !advance;
  assign accept  = push && advance;

  assign b       = in_item_i.in_byte;
  assign rom_val = e2g_pkg::SB_ROM[b];
  assign hi_off  = high_byte_q - e2g_pkg::DB_BASE;
  assign lo_off  = b - e2g_pkg::DB_BASE;
  assign pair_addr = 16'(hi_off) * 16'(e2g_pkg::DB_ROW) + 16'(lo_off);

  // Saturating length reported on status results
  assign count_wide = 32'(count_q);
  assign length = (count_wide > 32'h0000_FFFF) ? 16'hFFFF : count_wide[15:0];

  // Saturating byte count
  assign sum = {1'b0, count_q} + (CntW + 1)'(add_n);

  // Classify the incoming item and work out the next string state
  always_comb begin
    mode_d      = mode_q;
    high_byte_d = high_byte_q;
    error_d     = error_q;
    add_n       = 2'd0;
    emit        = 1'b0;
    job_d       = '{op: e2g_pkg::JOB_BYTE, word: 16'h0000, kind: e2g_pkg::KIND_DATA,
                    length: 16'h0000};
    ram_req_o   = '{we: 1'b0, waddr: in_item_i.map_address[e2g_pkg::MAP_AW-1:0],
                    wdata: in_item_i.map_word, re: 1'b0, raddr: pair_addr[e2g_pkg::MAP_AW-1:0]};
    if (accept) begin
      case (in_item_i.command)
        e2g_pkg::CMD_LOAD: begin
          ram_req_o.we = (32'(in_item_i.map_address) < e2g_pkg::MAP_WORDS);
        end
        e2g_pkg::CMD_CONVERT: begin
          if (!error_q) begin
            case (mode_q)
              MODE_SINGLE: begin
                if (b == e2g_pkg::SHIFT_OUT) begin
                  mode_d = MODE_DOUBLE;
                end else if (rom_val == 8'h00 && b != 8'h00) begin
                  error_d = 1'b1;
                end else begin
                  emit       = 1'b1;
                  job_d.word = {8'h00, rom_val};
                  add_n      = 2'd1;
                end
              end
              MODE_DOUBLE: begin
                if (b == e2g_pkg::SHIFT_IN) begin
                  mode_d = MODE_SINGLE;
                end else if (b < e2g_pkg::DB_BASE) begin
                  error_d = 1'b1;
                end else begin
                  high_byte_d = b;
                  mode_d      = MODE_HIGH;
                end
              end
              MODE_HIGH: begin
                mode_d = MODE_DOUBLE;
                if (b < e2g_pkg::DB_BASE) begin
                  error_d = 1'b1;
                end else begin
                  emit         = 1'b1;
                  job_d.op     = e2g_pkg::JOB_PAIR;
                  ram_req_o.re = 1'b1;
                  add_n        = 2'd2;
                end
              end
              default: begin
                mode_d = MODE_SINGLE;
              end
            endcase
          end
        end
        e2g_pkg::CMD_END: begin
          emit     = 1'b1;
          job_d.op = e2g_pkg::JOB_STATUS;
          if (error_q || mode_q != MODE_SINGLE) begin
            job_d.kind = e2g_pkg::KIND_BAD;
          end else begin
            job_d.kind   = e2g_pkg::KIND_OK;
            job_d.length = length;
          end
          mode_d      = MODE_SINGLE;
          high_byte_d = 8'h00;
          error_d     = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (accept && in_item_i.command == e2g_pkg::CMD_END) begin
      count_d = '0;
    end else if (sum[CntW]) begin
      count_d = '1;
    end else begin
      count_d = sum[CntW-1:0];
    end
  end

  assign stg_valid_d = advance ? (accept && emit) : stg_valid_q;

  // Hold string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SINGLE;
      high_byte_q <= 8'h00;
      error_q     <= 1'b0;
      count_q     <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      high_byte_q <= high_byte_d;
      error_q     <= error_d;
      count_q     <= count_d;
      stg_valid_q <= stg_valid_d;
    end
  end

  // Stage payload, aligned with the map read
  always_ff @(posedge clk_i) begin
    if (advance) begin
      stg_q <= job_d;
    end
  end

  // Transfer the job, merging in the map word for pairs
  assign q_push_o = stg_valid_q && !q_full_i;
  always_comb begin
    q_entry_o = stg_q;
    if (stg_q.op == e2g_pkg::JOB_PAIR) begin
      q_entry_o.word = ram_rdata_i;
    end
  end

endmodule

@@ rtl/core/e2g_queue.sv @@
module e2g_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  e2g_pkg::job_t entry_i,
  output logic          full_o,
  input  logic          pop_i,
  output e2g_pkg::job_t entry_o,
  output logic          empty_o
);

  localparam int Depth = e2g_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  e2g_pkg::job_t  slots_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = slots_q[rptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wptr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/core/e2g_back.sv @@
module e2g_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  e2g_pkg::job_t      q_entry_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output e2g_pkg::out_item_t out_item_o,
  output logic               empty,
  input  logic               pop
);

  logic               out_valid_q, out_valid_d;
  e2g_pkg::out_item_t out_q, out_d;
  logic               lo_pend_q, lo_pend_d;
  logic [7:0]         lo_byte_q, lo_byte_d;
  logic               free;

  // Output register is free when empty or being taken
  assign free    = !out_valid_q || pop;
  assign q_pop_o = free && !lo_pend_q && !q_empty_i;

  // Expand jobs into results, splitting pairs over two transfers
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    lo_pend_d   = lo_pend_q;
    lo_byte_d   = lo_byte_q;
    if (free) begin
      out_valid_d = 1'b0;
      if (lo_pend_q) begin
        out_valid_d = 1'b1;
        lo_pend_d   = 1'b0;
        out_d       = '{out_byte: lo_byte_q, kind: e2g_pkg::KIND_DATA,
                        out_length: 16'h0000, last: 1'b1};
      end else if (!q_empty_i) begin
        out_valid_d = 1'b1;
        case (q_entry_i.op)
          e2g_pkg::JOB_PAIR: begin
            lo_pend_d = 1'b1;
            lo_byte_d = q_entry_i.word[7:0];
            out_d     = '{out_byte: q_entry_i.word[15:8], kind: e2g_pkg::KIND_DATA,
                          out_length: 16'h0000, last: 1'b0};
          end
          e2g_pkg::JOB_STATUS: begin
            out_d = '{out_byte: 8'h00, kind: q_entry_i.kind,
                      out_length: q_entry_i.length, last: 1'b1};
          end
          default: begin
            out_d = '{out_byte: q_entry_i.word[7:0], kind: e2g_pkg::KIND_DATA,
                      out_length: 16'h0000, last: 1'b1};
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      lo_pend_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      lo_pend_q   <= lo_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    lo_byte_q <= lo_byte_d;
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

endmodule

@@ rtl/core/ebcdic_dbcs_to_gbk_converter_top.sv @@
// Mixed single/double-byte EBCDIC to GBK stream converter.
// Input channel: drive in_item_i and raise push; an item transfers at a clock
// edge where push is high and full is low. Commands load a pair-map word,
// convert one source byte, or end the string.
// Result channel: while empty is low the oldest result sits on out_item_o;
// it transfers at an edge where pop is high. Data bytes carry kind data,
// the end-of-string result carries ok with the length, or invalid.
// Throughput: one item per cycle while full is low; a double-byte pair gives
// two results, high byte first; a steady byte stream runs at one byte a cycle.
// Path: a result passes the stage register (aligned with the single read port
// of the pair map), a job queue slot, then the output register; items with no
// result leave nothing behind.
// Stalls: a four-entry job queue and the stage absorb backpressure; full
// rises once both are occupied and the output register is held.
// Reset clears the mode, error flag, count, queue and output at once; the
// pair map keeps no reset value and must be loaded before it is used.
`include "ebcdic_dbcs_to_gbk_converter_top_defines.svh"

module ebcdic_dbcs_to_gbk_converter_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  e2g_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output e2g_pkg::out_item_t out_item_o
);

  e2g_pkg::ram_req_t ram_req;
  logic [15:0]       ram_rdata;
  logic              q_push, q_full, q_pop, q_empty;
  e2g_pkg::job_t     q_in, q_out;

  e2g_ram #(
    .Width (16),
    .Depth (e2g_pkg::MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  e2g_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .q_push_o    (q_push),
    .q_entry_o   (q_in),
    .q_full_i    (q_full)
  );

  e2g_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .empty_o (q_empty)
  );

  e2g_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_entry_i  (q_out),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .out_item_o (out_item_o),
    .empty      (empty),
    .pop        (pop)
  );

  // Checks on internal hand-offs
  `E2G_ASSERT_NOW(a_no_push_when_full, q_push, !q_full, "job pushed into full queue")
  `E2G_ASSERT_NOW(a_ram_one_port, ram_req.re, !ram_req.we, "map read and write together")
  `E2G_ASSERT_NOW(a_status_is_last, !empty && out_item_o.kind != e2g_pkg::KIND_DATA,
                  out_item_o.last, "status result not marked last")
  `E2G_ASSERT_NEXT(a_pair_second_follows, !empty && pop && !out_item_o.last, !empty,
                   "second byte of pair missing")

endmodule

@@ tb/ebcdic_dbcs_to_gbk_converter_top_tb.sv @@
`timescale 1ns / 1ps

module ebcdic_dbcs_to_gbk_converter_top_tb;
  import e2g_pkg::*;

  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam logic [7:0]  BYTE_SO    = 8'h0E;
  localparam logic [7:0]  BYTE_SI    = 8'h0F;
  localparam logic [7:0]  LEAD_MIN   = 8'h40;
  localparam int          ROW_WORDS  = 192;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;

  // EBCDIC to ASCII for single-byte mode; zero marks an unmapped code
  localparam logic [7:0] EBCDIC_ASCII [256] = '{
    'h00,'h01,'h02,'h03,'h00,'h09,'h00,'h7F,'h00,'h00,'h00,'h0B,'h0C,'h0D,'h00,'h00,
    'h10,'h11,'h12,'h13,'h00,'h00,'h08,'h00,'h18,'h19,'h00,'h00,'h1C,'h1D,'h1E,'h1F,
    'h00,'h00,'h00,'h00,'h00,'h0A,'h17,'h1B,'h00,'h00,'h00,'h00,'h00,'h05,'h06,'h07,
    'h00,'h00,'h16,'h00,'h00,'h00,'h00,'h04,'h00,'h00,'h00,'h00,'h14,'h15,'h00,'h1A,
    'h20,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h2E,'h3C,'h28,'h2B,'h7C,
    'h26,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h21,'h00,'h2A,'h29,'h3B,'h00,
    'h2D,'h2F,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h2C,'h25,'h5F,'h3E,'h3F,
    'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h60,'h3A,'h23,'h40,'h27,'h3D,'h22,
    'h00,'h61,'h62,'h63,'h64,'h65,'h66,'h67,'h68,'h69,'h00,'h00,'h00,'h00,'h00,'h00,
    'h00,'h6A,'h6B,'h6C,'h6D,'h6E,'h6F,'h70,'h71,'h72,'h00,'h00,'h00,'h00,'h00,'h00,
    'h7E,'h00,'h73,'h74,'h75,'h76,'h77,'h78,'h79,'h7A,'h00,'h00,'h00,'h00,'h00,'h00,
    'h5E,'h00,'h5C,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h5B,'h5D,'h00,'h00,'h00,'h00,
    'h7B,'h41,'h42,'h43,'h44,'h45,'h46,'h47,'h48,'h49,'h00,'h00,'h00,'h00,'h00,'h00,
    'h7D,'h4A,'h4B,'h4C,'h4D,'h4E,'h4F,'h50,'h51,'h52,'h00,'h00,'h00,'h00,'h00,'h00,
    'h24,'h00,'h53,'h54,'h55,'h56,'h57,'h58,'h59,'h5A,'h00,'h00,'h00,'h00,'h00,'h00,
    'h30,'h31,'h32,'h33,'h34,'h35,'h36,'h37,'h38,'h39,'h00,'h00,'h00,'h00,'h00,'h00
  };

  logic      clk_i    = 1'b0;
  logic      rst_ni   = 1'b0;
  logic      push     = 1'b0;
  logic      full;
  logic      empty;
  logic      pop      = 1'b0;
  in_item_t  in_item  = '0;
  out_item_t out_item;

  // Source commands waiting to be offered, GBK results still owed
  in_item_t  src_items [$];
  out_item_t gbk_due [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit tx_hold = 1'b0;
  bit rx_hold = 1'b0;
  int mismatch_count = 0;
  int items_made = 0;

  // Converter state as the predictor sees it
  logic [15:0]     pair_words [MAP_WORDS];
  bit              dbcs_mode;
  bit              lead_pending;
  logic [7:0]      lead_byte;
  bit              err_flag;
  longint unsigned byte_tally;

  // Stimulus-side view of the same state, one step ahead of the block
  bit              gen_dbcs;
  bit              gen_lead;
  logic [7:0]      gen_lead_byte;
  bit              gen_err;
  bit              gen_written [MAP_WORDS];

  ebcdic_dbcs_to_gbk_converter_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor: results owed for one accepted command
  function automatic void owe_gbk(logic [7:0] b, logic [1:0] kind, logic [15:0] len,
                                  logic last);
    out_item_t r;
    r.out_byte   = b;
    r.kind       = kind;
    r.out_length = len;
    r.last       = last;
    gbk_due.push_back(r);
  endfunction

  function automatic void tally_bytes(int n);
    byte_tally = (byte_tally + n > COUNT_MAX) ? COUNT_MAX : byte_tally + n;
  endfunction

  function automatic void convert_source(logic [7:0] b);
    int          addr;
    logic [15:0] w;
    if (err_flag) return;
    if (!dbcs_mode) begin
      if (b == BYTE_SO) begin
        dbcs_mode = 1'b1;
      end else if (EBCDIC_ASCII[b] == 8'h00 && b != 8'h00) begin
        err_flag = 1'b1;
      end else begin
        owe_gbk(EBCDIC_ASCII[b], KIND_DATA, 16'd0, 1'b1);
        tally_bytes(1);
      end
    end else if (!lead_pending) begin
      if (b == BYTE_SI) begin
        dbcs_mode = 1'b0;
      end else if (b < LEAD_MIN) begin
        err_flag = 1'b1;
      end else begin
        lead_byte    = b;
        lead_pending = 1'b1;
      end
    end else begin
      lead_pending = 1'b0;
      if (b < LEAD_MIN) begin
        err_flag = 1'b1;
      end else begin
        addr = (int'(lead_byte) - int'(LEAD_MIN)) * ROW_WORDS + (int'(b) - int'(LEAD_MIN));
        w    = pair_words[addr];
        owe_gbk(w[15:8], KIND_DATA, 16'd0, 1'b0);
        owe_gbk(w[7:0], KIND_DATA, 16'd0, 1'b1);
        tally_bytes(2);
      end
    end
  endfunction

  function automatic void convert_command(in_item_t it);
    bit bad;
    case (it.command)
      CMD_LOAD: begin
        if (it.map_address < MAP_WORDS) pair_words[it.map_address] = it.map_word;
      end
      CMD_CONVERT: convert_source(it.in_byte);
      CMD_END: begin
        bad = err_flag || dbcs_mode || lead_pending;
        owe_gbk(8'h00, bad ? KIND_BAD : KIND_OK,
                bad ? 16'd0 : ((byte_tally > 65535) ? 16'hFFFF : 16'(byte_tally)), 1'b1);
        dbcs_mode    = 1'b0;
        lead_pending = 1'b0;
        lead_byte    = 8'h00;
        err_flag     = 1'b0;
        byte_tally   = 0;
      end
      default: ;
    endcase
  endfunction

  // Compare one transferred result with the oldest one owed
  function automatic void check_gbk(out_item_t got);
    out_item_t want;
    if (gbk_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: byte %h kind %0d len %0d last %b",
                 got.out_byte, got.kind, got.out_length, got.last);
      return;
    end
    want = gbk_due.pop_front();
    if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
        got.out_length !== want.out_length || got.last !== want.last) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result differs: want byte %h kind %0d len %0d last %b, got %h %0d %0d %b",
                 want.out_byte, want.kind, want.out_length, want.last,
                 got.out_byte, got.kind, got.out_length, got.last);
    end
  endfunction

  // Drive source commands; advance only after a transfer or while idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push    <= 1'b0;
      in_item <= '0;
    end else begin
      if (push && !full) convert_command(in_item);
      if (!push || !full) begin
        if (src_items.size() != 0 && !tx_hold && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_item <= src_items.pop_front();
          push    <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Take results; stall at random or hold off entirely
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_gbk(out_item);
      pop <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Queue one command and track its effect on the stimulus-side state
  function automatic void add_item(logic [1:0] cmd, logic [7:0] b, logic [15:0] a,
                                   logic [15:0] w);
    in_item_t it;
    it.command     = cmd;
    it.in_byte     = b;
    it.map_address = a;
    it.map_word    = w;
    src_items.push_back(it);
    items_made++;
    case (cmd)
      CMD_LOAD: begin
        if (a < MAP_WORDS) gen_written[a] = 1'b1;
      end
      CMD_CONVERT: begin
        if (gen_err) begin
        end else if (!gen_dbcs) begin
          if (b == BYTE_SO) gen_dbcs = 1'b1;
          else if (EBCDIC_ASCII[b] == 8'h00 && b != 8'h00) gen_err = 1'b1;
        end else if (!gen_lead) begin
          if (b == BYTE_SI) gen_dbcs = 1'b0;
          else if (b < LEAD_MIN) gen_err = 1'b1;
          else begin
            gen_lead      = 1'b1;
            gen_lead_byte = b;
          end
        end else begin
          gen_lead = 1'b0;
          if (b < LEAD_MIN) gen_err = 1'b1;
        end
      end
      CMD_END: begin
        gen_dbcs = 1'b0;
        gen_lead = 1'b0;
        gen_err  = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic int pair_addr(logic [7:0] lo);
    return (int'(gen_lead_byte) - int'(LEAD_MIN)) * ROW_WORDS + (int'(lo) - int'(LEAD_MIN));
  endfunction

  // Convert one byte; load its map word first if the lookup would hit an unwritten entry
  function automatic void send_byte(logic [7:0] b);
    int addr;
    if (!gen_err && gen_dbcs && gen_lead && b >= LEAD_MIN) begin
      addr = pair_addr(b);
      if (!gen_written[addr]) add_item(CMD_LOAD, 8'($urandom), 16'(addr), 16'($urandom));
    end
    add_item(CMD_CONVERT, b, 16'($urandom), 16'($urandom));
  endfunction

  function automatic logic [7:0] pick_single();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (EBCDIC_ASCII[b] == 8'h00 && b != 8'h00);
    return b;
  endfunction

  function automatic void random_load();
    logic [15:0] a;
    a = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(MAP_WORDS, 65535))
                                     : 16'($urandom_range(0, MAP_WORDS - 1));
    add_item(CMD_LOAD, 8'($urandom), a, 16'($urandom));
  endfunction

  // One string: mostly well-formed text, some loads and some noise
  function automatic void random_string();
    int         n;
    int         r;
    logic [7:0] lo;
    n = $urandom_range(1, 10);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        if (gen_dbcs && !gen_lead) send_byte(BYTE_SI);
        send_byte(pick_single());
      end else if (r < 76) begin
        if (!gen_dbcs) send_byte(BYTE_SO);
        send_byte(8'($urandom_range(LEAD_MIN, 255)));
        lo = 8'($urandom_range(LEAD_MIN, 255));
        // overwrite the word between the two halves of a pair now and then
        if (gen_lead && !gen_err && $urandom_range(0, 3) == 0)
          add_item(CMD_LOAD, 8'($urandom), 16'(pair_addr(lo)), 16'($urandom));
        send_byte(lo);
      end else if (r < 82) begin
        random_load();
      end else if (r < 85) begin
        add_item(CMD_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
      end else if (r < 93) begin
        case ($urandom_range(0, 3))
          0: send_byte(BYTE_SO);
          1: send_byte(BYTE_SI);
          2: send_byte(8'($urandom_range(0, LEAD_MIN - 1)));
          default: send_byte(8'($urandom));
        endcase
      end
    end
    if (gen_dbcs && $urandom_range(0, 9) != 0) begin
      if (gen_lead) send_byte(8'($urandom_range(LEAD_MIN, 255)));
      send_byte(BYTE_SI);
    end
    add_item(CMD_END, 8'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  function automatic void random_strings(int count);
    int stop;
    stop = items_made + count;
    while (items_made < stop) random_string();
  endfunction

  function automatic void directed_items();
    // loads at both ends of the map, one out of range, and an unused command
    add_item(CMD_LOAD, 8'h00, 16'd0, 16'hA1B2);
    add_item(CMD_LOAD, 8'hFF, 16'(MAP_WORDS - 1), 16'hFFFF);
    add_item(CMD_LOAD, 8'h00, 16'hFFFF, 16'h0000);
    add_item(CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);
    // byte zero, a letter, the lowest and highest pairs, then a clean end
    add_item(CMD_CONVERT, 8'h00, 16'd0, 16'd0);
    add_item(CMD_CONVERT, 8'hC1, 16'd0, 16'd0);
    add_item(CMD_CONVERT, BYTE_SO, 16'd0, 16'd0);
    add_item(CMD_CONVERT, 8'h40, 16'd0, 16'd0);
    add_item(CMD_CONVERT, 8'h40, 16'd0, 16'd0);
    add_item(CMD_CONVERT, 8'hFF, 16'd0, 16'd0);
    add_item(CMD_CONVERT, 8'hFF, 16'd0, 16'd0);
    add_item(CMD_CONVERT, BYTE_SI, 16'd0, 16'd0);
    add_item(CMD_END, 8'h00, 16'd0, 16'd0);
    // end while still in double-byte mode
    add_item(CMD_CONVERT, BYTE_SO, 16'd0, 16'd0);
    add_item(CMD_END, 8'h00, 16'd0, 16'd0);
    // end with a high byte pending
    add_item(CMD_CONVERT, BYTE_SO, 16'd0, 16'd0);
    add_item(CMD_CONVERT, 8'h40, 16'd0, 16'd0);
    add_item(CMD_END, 8'h00, 16'd0, 16'd0);
    // unmapped single byte, then a valid byte that must be dropped
    add_item(CMD_CONVERT, 8'hFF, 16'd0, 16'd0);
    add_item(CMD_CONVERT, 8'hC1, 16'd0, 16'd0);
    add_item(CMD_END, 8'h00, 16'd0, 16'd0);
    // high byte below the double-byte range
    add_item(CMD_CONVERT, BYTE_SO, 16'd0, 16'd0);
    add_item(CMD_CONVERT, 8'h3F, 16'd0, 16'd0);
    add_item(CMD_END, 8'h00, 16'd0, 16'd0);
    // shift-in where the low byte belongs
    add_item(CMD_CONVERT, BYTE_SO, 16'd0, 16'd0);
    add_item(CMD_CONVERT, 8'h40, 16'd0, 16'd0);
    add_item(CMD_CONVERT, BYTE_SI, 16'd0, 16'd0);
    add_item(CMD_END, 8'h00, 16'd0, 16'd0);
  endfunction

  task automatic wait_drained();
    while (src_items.size() != 0 || push || gbk_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    #2_000_000;
    $display("ebcdic_dbcs_to_gbk_converter_top: mismatch");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sender sparse gaps, receiver mostly stalled
    tx_idle_pct = 34;
    rx_idle_pct = 81;
    directed_items();
    random_strings(360);
    // hold the receiver off long enough for the block to fill and stall
    rx_hold = 1'b1;
    repeat (300) @(negedge clk_i);
    rx_hold = 1'b0;
    random_strings(340);
    wait_drained();

    // sender mostly idle, receiver sparse gaps
    tx_idle_pct = 81;
    rx_idle_pct = 34;
    random_strings(360);
    while (src_items.size() > 200) @(negedge clk_i);
    // pause the sender until every owed result has come out
    tx_hold = 1'b1;
    while (push || gbk_due.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    tx_hold = 1'b0;
    random_strings(340);
    wait_drained();

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_strings(70);
    wait_drained();
    repeat (10) @(negedge clk_i);

    if (mismatch_count == 0 && gbk_due.size() == 0) begin
      $display("ebcdic_dbcs_to_gbk_converter_top: match");
    end else begin
      $display("ebcdic_dbcs_to_gbk_converter_top: mismatch");
    end
    $finish;
  end

endmodule

@@ ebcdic_dbcs_to_gbk_converter_top.f @@
+incdir+rtl/core
rtl/core/e2g_pkg.sv
rtl/core/e2g_ram.sv
rtl/core/e2g_front.sv
rtl/core/e2g_queue.sv
rtl/core/e2g_back.sv
rtl/core/ebcdic_dbcs_to_gbk_converter_top.sv
tb/ebcdic_dbcs_to_gbk_converter_top_tb.sv
